FILE: rtl/ppas_pkg.sv
// Shared types and constants for the Paxos proposer/acceptor step block.
// No dependencies; every other file but ppas_if.sv takes names from here by scope.
`default_nettype none

package ppas_pkg;

   // message function codes on the input channel
   localparam logic [2:0] OP_PREPARE     = 3'd0;
   localparam logic [2:0] OP_PREPARE_ACK = 3'd1;
   localparam logic [2:0] OP_ACCEPT      = 3'd2;
   localparam logic [2:0] OP_ACCEPT_ACK  = 3'd3;
   localparam logic [2:0] OP_START       = 3'd4;

   // kinds of outgoing message
   localparam logic [2:0] KIND_PREPARE     = 3'd0;
   localparam logic [2:0] KIND_PREPARE_ACK = 3'd1;
   localparam logic [2:0] KIND_ACCEPT      = 3'd2;
   localparam logic [2:0] KIND_ACCEPT_ACK  = 3'd3;
   localparam logic [2:0] KIND_CHOSE       = 3'd4;

   // configuration register indexes
   localparam logic [1:0] REG_NODE_ID   = 2'd0;
   localparam logic [1:0] REG_QUORUM    = 2'd1;
   localparam logic [1:0] REG_OWN_VALUE = 2'd2;

   localparam logic [3:0] NODE_ID_RESET   = 4'd0;
   localparam logic [4:0] QUORUM_RESET    = 5'd2;
   localparam logic [7:0] OWN_VALUE_RESET = 8'd0;
   localparam logic [3:0] ROUND_RESET     = 4'd2;

   localparam logic [4:0]        CNT_MAX   = 5'd31;
   localparam logic signed [8:0] BEST_NONE = -9'sd1;

   // decoupling queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] sender;
      logic [7:0] proposal;
      logic [7:0] payload;
   } entry_type;

   typedef struct packed {
      logic [2:0] out_kind;
      logic       to_all;
      logic [3:0] dest;
      logic [7:0] out_proposal;
      logic [7:0] out_value;
   } rsp_type;

   typedef struct packed {
      logic [3:0] node_id;
      logic [4:0] quorum;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

FILE: rtl/ppas_if.sv
// Valid/ready channel interfaces for request and response beats.
// Stand-alone; no package dependency.
`default_nettype none

interface ppas_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [3:0] sender;
   logic [7:0] proposal;
   logic [7:0] payload;

   modport source (output valid, output func, output sender, output proposal,
                   output payload, input ready);
   modport sink   (input valid, input func, input sender, input proposal,
                   input payload, output ready);
endinterface

interface ppas_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic       to_all;
   logic [3:0] dest;
   logic [7:0] out_proposal;
   logic [7:0] out_value;

   modport source (output valid, output out_kind, output to_all, output dest,
                   output out_proposal, output out_value, input ready);
   modport sink   (input valid, input out_kind, input to_all, input dest,
                   input out_proposal, input out_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/paxos_proposer_acceptor_step.sv
// Single-decree Paxos node (proposer and acceptor) with a valid/ready
// request channel, a valid/ready response channel and an APB-style CSR port.
//
// Use: each request beat is one message (prepare, prepare-ack, accept,
// accept-ack, or start). Each yields at most one response beat: a unicast
// reply, a broadcast prepare/accept, or a chose report. Malformed messages
// (unknown function, sender not below MAX_NODES except on start) are dropped at the front.
// Flow: a kept request is written into a two-entry queue, and the execute
// stage pops it into the output register; one message per cycle is taken
// while the response side is ready. When the response side stalls the output
// register holds, the queue fills, and req ready drops once it is full.
// Reset (synchronous, active high) restores round 2, clears the acceptor
// state and counters, and sets node_id 0, quorum 2, own_value 0.
// CSRs: node_id at 0x0, quorum at 0x4, own_value at 0x8; write them only
// while no message is in flight. A write of own_value also loads the value
// being proposed. pready is tied high.
`default_nettype none

module paxos_proposer_acceptor_step #(
   parameter int MAX_NODES = 16
) (
   input  wire         clock,
   input  wire         reset,
   ppas_req_if.sink    req_bus,
   ppas_rsp_if.source  rsp_bus,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [3:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [3:0] node_id_ff, node_id_in;
   logic [4:0] quorum_ff, quorum_in;
   logic [7:0] own_value_ff, own_value_in;

   logic                csr_wr;
   logic [1:0]          csr_idx;
   logic                own_load;
   ppas_pkg::cfg_type   cfg;
   ppas_pkg::entry_type req_item;
   ppas_pkg::entry_type push_item;
   ppas_pkg::entry_type head_item;
   ppas_pkg::qstat_type q_stat;
   ppas_pkg::rsp_type   rsp;
   logic                q_push;
   logic                q_pop;
   logic                req_ready;
   logic                rsp_valid;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_comb begin
      node_id_in   = node_id_ff;
      quorum_in    = quorum_ff;
      own_value_in = own_value_ff;
      own_load     = 1'b0;
      if (csr_wr) begin
         case (csr_idx)
            ppas_pkg::REG_NODE_ID:   node_id_in = pwdata[3:0];
            ppas_pkg::REG_QUORUM:    quorum_in  = pwdata[4:0];
            ppas_pkg::REG_OWN_VALUE: begin
               own_value_in = pwdata[7:0];
               own_load     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ppas_pkg::REG_NODE_ID:   prdata = {28'd0, node_id_ff};
         ppas_pkg::REG_QUORUM:    prdata = {27'd0, quorum_ff};
         ppas_pkg::REG_OWN_VALUE: prdata = {24'd0, own_value_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff   <= ppas_pkg::NODE_ID_RESET;
         quorum_ff    <= ppas_pkg::QUORUM_RESET;
         own_value_ff <= ppas_pkg::OWN_VALUE_RESET;
      end else begin
         node_id_ff   <= node_id_in;
         quorum_ff    <= quorum_in;
         own_value_ff <= own_value_in;
      end
   end

   assign cfg.node_id = node_id_ff;
   assign cfg.quorum  = quorum_ff;

   assign req_item = '{req_bus.func, req_bus.sender, req_bus.proposal, req_bus.payload};
   assign req_bus.ready = req_ready;

   ppas_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .req_valid (req_bus.valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   ppas_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   ppas_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .own_load       (own_load),
      .own_load_value (own_value_in),
      .q_stat         (q_stat),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp            (rsp)
   );

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.out_kind     = rsp.out_kind;
   assign rsp_bus.to_all       = rsp.to_all;
   assign rsp_bus.dest         = rsp.dest;
   assign rsp_bus.out_proposal = rsp.out_proposal;
   assign rsp_bus.out_value    = rsp.out_value;

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (!q_stat.empty && (!rsp_valid || rsp_bus.ready)) |-> q_pop)
      else $error("execute stage idle with work queued and output free");

   a_drop_unknown: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.func > ppas_pkg::OP_START))
      |-> !q_push)
      else $error("unknown message function reached the queue");

   a_empty_to_idle: assert property (@(posedge clock) disable iff (reset)
      (q_stat.empty && !q_push && rsp_valid && rsp_bus.ready) |=> !rsp_valid)
      else $error("response shown with no message executed");
`endif

endmodule

`default_nettype wire

FILE: rtl/ppas_front.sv
// Front end: accepts request beats, drops malformed messages, feeds the queue.
// Depends on ppas_pkg.
`default_nettype none

module ppas_front #(
   parameter int MAX_NODES = 16
) (
   input  wire                 req_valid,
   input  ppas_pkg::entry_type req_item,
   output logic                req_ready,
   input  ppas_pkg::qstat_type q_stat,
   output logic                q_push,
   output ppas_pkg::entry_type q_item
);

   logic known_func;
   logic sender_ok;
   logic keep;

   always_comb begin
      known_func = (req_item.func <= ppas_pkg::OP_START);
      // start comes from the host, so its sender field means nothing
      sender_ok  = (req_item.func == ppas_pkg::OP_START) ||
                   ({1'b0, req_item.sender} < 5'(MAX_NODES));
      keep       = known_func && sender_ok;
   end

   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready && keep;
   assign q_item    = req_item;

endmodule

`default_nettype wire

FILE: rtl/ppas_fifo.sv
// Short queue that decouples the front end from the execute stage.
// Depends on ppas_pkg for the entry type and depth.
`default_nettype none

module ppas_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  ppas_pkg::entry_type push_item,
   input  wire                 pop,
   output ppas_pkg::entry_type head_item,
   output ppas_pkg::qstat_type stat
);

   localparam int PW = ppas_pkg::Q_PTR_W;
   localparam int CW = ppas_pkg::Q_CNT_W;
   localparam logic [PW-1:0] LAST = PW'(ppas_pkg::Q_DEPTH - 1);

   ppas_pkg::entry_type mem_ff [ppas_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(ppas_pkg::Q_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/ppas_back.sv
// Execute stage: holds proposer/acceptor state, runs one message per beat,
// and registers the outgoing message. Depends on ppas_pkg.
`default_nettype none

module ppas_back (
   input  wire                 clock,
   input  wire                 reset,
   input  ppas_pkg::cfg_type   cfg,
   input  wire                 own_load,
   input  wire [7:0]           own_load_value,
   input  ppas_pkg::qstat_type q_stat,
   input  ppas_pkg::entry_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ppas_pkg::rsp_type   rsp
);

   logic [3:0]        round_ff, round_in;
   logic [7:0]        myprop_ff, myprop_in;
   logic [7:0]        promised_ff, promised_in;
   logic [7:0]        acc_num_ff, acc_num_in;
   logic [7:0]        acc_byte_ff, acc_byte_in;
   logic signed [8:0] best_ff, best_in;
   logic [7:0]        propval_ff, propval_in;
   logic [4:0]        pack_cnt_ff, pack_cnt_in;
   logic [4:0]        aack_cnt_ff, aack_cnt_in;
   logic [7:0]        decided_ff, decided_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ppas_pkg::rsp_type rsp_ff, rsp_in;

   logic       has_rsp;
   logic       do_start;
   logic [3:0] round_base;
   logic [7:0] pv;
   logic [7:0] pm;
   logic       pack_hit;
   logic       aack_hit;
   logic [4:0] pack_bump;
   logic [4:0] aack_bump;

   // advance whenever a message is queued and the output register is free or being drained
   assign q_pop = !q_stat.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pack_hit  = ({1'b0, pack_cnt_ff} + 6'd1) == {1'b0, cfg.quorum};
      aack_hit  = ({1'b0, aack_cnt_ff} + 6'd1) == {1'b0, cfg.quorum};
      pack_bump = (pack_cnt_ff == ppas_pkg::CNT_MAX) ? pack_cnt_ff : pack_cnt_ff + 5'd1;
      aack_bump = (aack_cnt_ff == ppas_pkg::CNT_MAX) ? aack_cnt_ff : aack_cnt_ff + 5'd1;
   end

   always_comb begin
      round_in    = round_ff;
      myprop_in   = myprop_ff;
      promised_in = promised_ff;
      acc_num_in  = acc_num_ff;
      acc_byte_in = acc_byte_ff;
      best_in     = best_ff;
      propval_in  = propval_ff;
      pack_cnt_in = pack_cnt_ff;
      aack_cnt_in = aack_cnt_ff;
      decided_in  = decided_ff;
      rsp_in      = rsp_ff;
      has_rsp     = 1'b0;
      do_start    = 1'b0;
      round_base  = round_ff;
      pv          = propval_ff;
      pm          = promised_ff;

      if (q_pop) begin
         case (q_item.func)
            ppas_pkg::OP_PREPARE: begin
               if (q_item.proposal > promised_ff) begin
                  promised_in = q_item.proposal;
               end
               has_rsp = 1'b1;
               rsp_in  = '{ppas_pkg::KIND_PREPARE_ACK, 1'b0, q_item.sender,
                           acc_num_ff, acc_byte_ff};
            end
            ppas_pkg::OP_PREPARE_ACK: begin
               if (q_item.payload != 8'd0 &&
                   $signed({1'b0, q_item.proposal}) > best_ff) begin
                  pv      = q_item.payload;
                  best_in = $signed({1'b0, q_item.proposal});
               end
               propval_in  = pv;
               pack_cnt_in = pack_bump;
               if (pack_hit) begin
                  best_in = ppas_pkg::BEST_NONE;
                  has_rsp = 1'b1;
                  rsp_in  = '{ppas_pkg::KIND_ACCEPT, 1'b1, 4'd0, myprop_ff, pv};
               end
            end
            ppas_pkg::OP_ACCEPT: begin
               if (q_item.proposal >= promised_ff) begin
                  pm          = q_item.proposal;
                  acc_num_in  = q_item.proposal;
                  acc_byte_in = q_item.payload;
               end
               promised_in = pm;
               has_rsp     = 1'b1;
               rsp_in      = '{ppas_pkg::KIND_ACCEPT_ACK, 1'b0, q_item.sender, pm, 8'd0};
            end
            ppas_pkg::OP_ACCEPT_ACK: begin
               if (q_item.proposal > myprop_ff) begin
                  // someone is ahead: catch up on the round and retry
                  if (q_item.proposal[7:4] > round_ff) begin
                     round_base = q_item.proposal[7:4];
                  end
                  do_start = 1'b1;
               end else begin
                  aack_cnt_in = aack_bump;
                  if (aack_hit) begin
                     decided_in = propval_ff;
                     has_rsp    = 1'b1;
                     rsp_in     = '{ppas_pkg::KIND_CHOSE, 1'b0, cfg.node_id,
                                    q_item.proposal, propval_ff};
                  end
               end
            end
            ppas_pkg::OP_START: begin
               do_start = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (do_start) begin
         round_in    = round_base + 4'd1;
         myprop_in   = {round_in, cfg.node_id};
         pack_cnt_in = 5'd0;
         aack_cnt_in = 5'd0;
         has_rsp     = 1'b1;
         rsp_in      = '{ppas_pkg::KIND_PREPARE, 1'b1, 4'd0, myprop_in, 8'd0};
      end

      if (own_load) begin
         propval_in = own_load_value;
      end

      if (q_pop) begin
         rsp_valid_in = has_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff     <= ppas_pkg::ROUND_RESET;
         myprop_ff    <= 8'd0;
         promised_ff  <= 8'd0;
         acc_num_ff   <= 8'd0;
         acc_byte_ff  <= 8'd0;
         best_ff      <= 9'sd0;
         propval_ff   <= ppas_pkg::OWN_VALUE_RESET;
         pack_cnt_ff  <= 5'd0;
         aack_cnt_ff  <= 5'd0;
         decided_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         round_ff     <= round_in;
         myprop_ff    <= myprop_in;
         promised_ff  <= promised_in;
         acc_num_ff   <= acc_num_in;
         acc_byte_ff  <= acc_byte_in;
         best_ff      <= best_in;
         propval_ff   <= propval_in;
         pack_cnt_ff  <= pack_cnt_in;
         aack_cnt_ff  <= aack_cnt_in;
         decided_ff   <= decided_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
